// ===== design/twg_pkg.sv =====
// Package for the tile walk generator: payload structs, register indexes,
// controller states, datapath operations and status.
// No dependencies.
package twg_pkg;

  localparam int MAX_DIRECTIONS = 8;
  localparam int CFG_IDX_W      = 3;
  localparam logic [3:0] DIR_CAP = 4'(MAX_DIRECTIONS < 8 ? MAX_DIRECTIONS : 8);

  typedef logic signed [35:0] coord_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_LO, REG_X_HI, REG_Z_LO, REG_Z_HI,
    REG_TILE_W, REG_TILE_D, REG_DIRS, REG_ORDER
  } cfg_reg_t;

  typedef enum logic {
    FUNC_RESTART = 1'b0,
    FUNC_FETCH   = 1'b1
  } func_t;

  typedef struct packed {
    func_t              func;
    logic signed [31:0] y_lo;
    logic signed [31:0] y_hi;
  } in_item_t;

  typedef struct packed {
    logic               item_valid;
    logic signed [31:0] x_begin;
    logic signed [31:0] x_end;
    logic signed [31:0] z_begin;
    logic signed [31:0] z_end;
    logic [2:0]         direction_index;
    logic [63:0]        item_candidates;
    logic [63:0]        total_candidates;
    logic               total_saturated;
    logic               walk_done;
    logic               error_code;
  } out_item_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LATCH, OP_FETCH, OP_CHECK, OP_DIV_LOAD, OP_DIV_STEP, OP_DIV_STORE,
    OP_RST_FIN, OP_M1, OP_M2, OP_M3, OP_M4, OP_M5, OP_M6, OP_M7, OP_M8, OP_M9,
    OP_DIR, OP_LIN, OP_SP_CONT, OP_SP_TRY, OP_OUT
  } dp_op_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_DIV_LOAD, S_DIV_RUN, S_DIV_STORE, S_RST_FIN,
    S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_M8, S_M9,
    S_DIR, S_LIN, S_SP_CONT, S_SP_TRY, S_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic empty;
    logic div_last;
    logic div_sel_last;
    logic finished;
    logic dir_wrap;
    logic spiral;
    logic cont_step;
    logic try_done;
    logic out_free;
  } dp_status_t;

endpackage

// ===== design/tile_walk_generator.sv =====
// Top level of the tile walk generator: controller plus datapath.
// Depends on twg_pkg, twg_ctrl and twg_datapath.
//
//   port group   handshake             payload
//   in_          in_valid / in_ready   in_data  (twg_pkg::in_item_t)
//   out_         out_valid / out_ready out_data (twg_pkg::out_item_t)
//   cfg_         cfg_we                cfg_index, cfg_data
//
// A fetch runs through the shared 32x32 multiplier and the candidate count
// sum; when the tile changes it also takes a linear or spiral step, and a
// spiral side change tries one side after another.
// A restart runs four 32-step divisions on the shared radix-2 divider, unless
// the bounds are empty. A fetch after a finished walk goes straight to output.
// Reset is synchronous and leaves the walk finished. A waiting result sits in
// the output register, and the next beat is taken in while it waits.
module tile_walk_generator (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  twg_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output twg_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [twg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_data
);

  twg_pkg::dp_op_t     op;
  twg_pkg::dp_status_t status;

  twg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_data.func),
    .status   (status),
    .in_ready (in_ready),
    .op       (op)
  );

  twg_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .op        (op),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== design/twg_ctrl.sv =====
// Controller state machine of the tile walk generator.
// Depends on twg_pkg; drives the datapath by operation codes.
module twg_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  twg_pkg::func_t         in_func,
  input  twg_pkg::dp_status_t    status,
  output logic                   in_ready,
  output twg_pkg::dp_op_t        op
);

  twg_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= twg_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      twg_pkg::S_IDLE: begin
        if (in_valid) begin
          if (in_func == twg_pkg::FUNC_RESTART) state_nxt = twg_pkg::S_CHECK;
          else if (status.finished) state_nxt = twg_pkg::S_OUT;
          else state_nxt = twg_pkg::S_M1;
        end
      end
      twg_pkg::S_CHECK: state_nxt = status.empty ? twg_pkg::S_OUT : twg_pkg::S_DIV_LOAD;
      twg_pkg::S_DIV_LOAD: state_nxt = twg_pkg::S_DIV_RUN;
      twg_pkg::S_DIV_RUN: if (status.div_last) state_nxt = twg_pkg::S_DIV_STORE;
      twg_pkg::S_DIV_STORE: begin
        state_nxt = status.div_sel_last ? twg_pkg::S_RST_FIN : twg_pkg::S_DIV_LOAD;
      end
      twg_pkg::S_RST_FIN: state_nxt = twg_pkg::S_OUT;
      twg_pkg::S_M1: state_nxt = twg_pkg::S_M2;
      twg_pkg::S_M2: state_nxt = twg_pkg::S_M3;
      twg_pkg::S_M3: state_nxt = twg_pkg::S_M4;
      twg_pkg::S_M4: state_nxt = twg_pkg::S_M5;
      twg_pkg::S_M5: state_nxt = twg_pkg::S_M6;
      twg_pkg::S_M6: state_nxt = twg_pkg::S_M7;
      twg_pkg::S_M7: state_nxt = twg_pkg::S_M8;
      twg_pkg::S_M8: state_nxt = twg_pkg::S_M9;
      twg_pkg::S_M9: state_nxt = twg_pkg::S_DIR;
      twg_pkg::S_DIR: begin
        if (!status.dir_wrap) state_nxt = twg_pkg::S_OUT;
        else if (status.spiral) state_nxt = twg_pkg::S_SP_CONT;
        else state_nxt = twg_pkg::S_LIN;
      end
      twg_pkg::S_LIN: state_nxt = twg_pkg::S_OUT;
      twg_pkg::S_SP_CONT: state_nxt = status.cont_step ? twg_pkg::S_OUT : twg_pkg::S_SP_TRY;
      twg_pkg::S_SP_TRY: if (status.try_done) state_nxt = twg_pkg::S_OUT;
      twg_pkg::S_OUT: if (status.out_free) state_nxt = twg_pkg::S_IDLE;
      default: state_nxt = twg_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    op       = twg_pkg::OP_NONE;
    case (state_r)
      twg_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op = (in_func == twg_pkg::FUNC_RESTART) ? twg_pkg::OP_LATCH : twg_pkg::OP_FETCH;
        end
      end
      twg_pkg::S_CHECK:     op = twg_pkg::OP_CHECK;
      twg_pkg::S_DIV_LOAD:  op = twg_pkg::OP_DIV_LOAD;
      twg_pkg::S_DIV_RUN:   op = twg_pkg::OP_DIV_STEP;
      twg_pkg::S_DIV_STORE: op = twg_pkg::OP_DIV_STORE;
      twg_pkg::S_RST_FIN:   op = twg_pkg::OP_RST_FIN;
      twg_pkg::S_M1:        op = twg_pkg::OP_M1;
      twg_pkg::S_M2:        op = twg_pkg::OP_M2;
      twg_pkg::S_M3:        op = twg_pkg::OP_M3;
      twg_pkg::S_M4:        op = twg_pkg::OP_M4;
      twg_pkg::S_M5:        op = twg_pkg::OP_M5;
      twg_pkg::S_M6:        op = twg_pkg::OP_M6;
      twg_pkg::S_M7:        op = twg_pkg::OP_M7;
      twg_pkg::S_M8:        op = twg_pkg::OP_M8;
      twg_pkg::S_M9:        op = twg_pkg::OP_M9;
      twg_pkg::S_DIR:       op = twg_pkg::OP_DIR;
      twg_pkg::S_LIN:       op = twg_pkg::OP_LIN;
      twg_pkg::S_SP_CONT:   op = twg_pkg::OP_SP_CONT;
      twg_pkg::S_SP_TRY:    op = twg_pkg::OP_SP_TRY;
      twg_pkg::S_OUT:       op = status.out_free ? twg_pkg::OP_OUT : twg_pkg::OP_NONE;
      default:              op = twg_pkg::OP_NONE;
    endcase
  end

endmodule

// ===== design/twg_datapath.sv =====
// Datapath of the tile walk generator: registers, shared divider and
// multiplier, walk position logic and the output register. Depends on twg_pkg.
module twg_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [twg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                      cfg_data,
  input  twg_pkg::in_item_t                in_data,
  input  twg_pkg::dp_op_t                  op,
  output twg_pkg::dp_status_t              status,
  output logic                             out_valid,
  input  logic                             out_ready,
  output twg_pkg::out_item_t               out_data
);

  function automatic twg_pkg::coord_t cmax(twg_pkg::coord_t a, twg_pkg::coord_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic twg_pkg::coord_t cmin(twg_pkg::coord_t a, twg_pkg::coord_t b);
    return (a < b) ? a : b;
  endfunction

  logic signed [31:0] cfg_xlo_r, cfg_xhi_r, cfg_zlo_r, cfg_zhi_r;
  logic [30:0]        cfg_tw_r, cfg_td_r;
  logic [3:0]         cfg_dirs_r;
  logic               cfg_order_r;

  logic signed [31:0] s_xlo_r, s_xhi_r, s_zlo_r, s_zhi_r, hlo_r, hhi_r;
  logic [30:0]        s_tw_r, s_td_r;
  logic [3:0]         s_dirs_r;
  logic               s_order_r;

  twg_pkg::coord_t col_r, row_r, colc_r, rowc_r, ccol_r, crow_r;
  twg_pkg::coord_t radius_r, limit_r, stop_r, try_r_r;
  logic [2:0]      side_r, try_side_r;
  logic [3:0]      tries_r;
  logic [2:0]      dir_r, dir_idx_r;
  logic [63:0]     total_r, cnt_r, prod_r, plo_r;
  logic [31:0]     hi_r;
  logic            sat_r, isat_r, finished_r, item_r, err_r;

  logic [31:0] xs1_r, zs1_r, hspan_r, xspan_r, zspan_r;
  logic [31:0] dq_r;
  logic [32:0] rem_r;
  logic [30:0] divisor_r;
  logic [4:0]  dcnt_r;
  logic [1:0]  div_sel_r;

  logic signed [31:0] xb_r, xe_r, zb_r, ze_r;

  logic               out_valid_r;
  twg_pkg::out_item_t out_data_r;

  logic signed [32:0] xs_c, zs_c, hs_c;
  logic               empty_c;
  logic [32:0]        rem_sh_c;
  logic               ge_c;
  logic [31:0]        mul_a_c, mul_b_c;
  logic [63:0]        mul_p_c;
  logic signed [33:0] xsum_c, zsum_c;
  logic [64:0]        sum_c, tsum_c;
  logic [3:0]         dir_inc_c;
  logic               wrap_c;
  twg_pkg::coord_t    q_c;
  logic [2:0]         eff_side_c;
  twg_pkg::coord_t    eff_r_c, ent_col_c, ent_row_c, ent_stop_c, lo_c, hi_c, pos_c;
  logic               ent_ok_c, over_c, cont_c;

  assign xs_c = 33'(s_xhi_r) - 33'(s_xlo_r);
  assign zs_c = 33'(s_zhi_r) - 33'(s_zlo_r);
  assign hs_c = 33'(hhi_r) - 33'(hlo_r);
  assign empty_c = (xs_c <= 0) || (zs_c <= 0) || (hs_c <= 0);

  assign rem_sh_c = {rem_r[31:0], dq_r[31]};
  assign ge_c     = rem_sh_c >= {2'b00, divisor_r};
  assign q_c      = twg_pkg::coord_t'({4'b0000, dq_r});

  always_comb begin
    mul_a_c = prod_r[31:0];
    mul_b_c = zspan_r;
    case (op)
      twg_pkg::OP_M1: begin
        mul_a_c = col_r[31:0];
        mul_b_c = {1'b0, s_tw_r};
      end
      twg_pkg::OP_M2: begin
        mul_a_c = row_r[31:0];
        mul_b_c = {1'b0, s_td_r};
      end
      twg_pkg::OP_M5: begin
        mul_a_c = xspan_r;
        mul_b_c = hspan_r;
      end
      twg_pkg::OP_M7: begin
        mul_a_c = hi_r;
        mul_b_c = zspan_r;
      end
      default: begin
        mul_a_c = prod_r[31:0];
        mul_b_c = zspan_r;
      end
    endcase
  end

  assign mul_p_c = {32'd0, mul_a_c} * {32'd0, mul_b_c};
  assign xsum_c  = 34'(xb_r) + 34'({3'b000, s_tw_r});
  assign zsum_c  = 34'(zb_r) + 34'({3'b000, s_td_r});
  assign sum_c   = {1'b0, prod_r[31:0], 32'd0} + {1'b0, plo_r};
  assign tsum_c  = {1'b0, total_r} + {1'b0, cnt_r};

  assign dir_inc_c = {1'b0, dir_r} + 4'd1;
  assign wrap_c    = dir_inc_c >= s_dirs_r;

  always_comb begin
    case (side_r)
      3'd1, 3'd3: cont_c = row_r != stop_r;
      3'd2, 3'd4: cont_c = col_r != stop_r;
      default:    cont_c = 1'b0;
    endcase
  end

  assign eff_side_c = (try_side_r > 3'd4) ? 3'd1 : try_side_r;
  assign eff_r_c    = (try_side_r > 3'd4) ? try_r_r + 36'sd1 : try_r_r;
  assign over_c     = eff_r_c > limit_r;

  always_comb begin
    lo_c = '0;
    hi_c = '0;
    pos_c = '0;
    ent_ok_c = 1'b0;
    ent_col_c = '0;
    ent_row_c = '0;
    case (eff_side_c)
      3'd1: begin
        pos_c = ccol_r + eff_r_c;
        lo_c = cmax('0, crow_r - eff_r_c + 36'sd1);
        hi_c = cmin(rowc_r - 36'sd1, crow_r + eff_r_c);
        ent_ok_c = (pos_c < colc_r) && (lo_c <= hi_c);
        ent_col_c = pos_c;
        ent_row_c = lo_c;
      end
      3'd2: begin
        pos_c = crow_r + eff_r_c;
        lo_c = cmin(colc_r - 36'sd1, ccol_r + eff_r_c - 36'sd1);
        hi_c = cmax('0, ccol_r - eff_r_c);
        ent_ok_c = (pos_c < rowc_r) && (lo_c >= hi_c);
        ent_row_c = pos_c;
        ent_col_c = lo_c;
      end
      3'd3: begin
        pos_c = ccol_r - eff_r_c;
        lo_c = cmin(rowc_r - 36'sd1, crow_r + eff_r_c - 36'sd1);
        hi_c = cmax('0, crow_r - eff_r_c);
        ent_ok_c = (pos_c >= 0) && (lo_c >= hi_c);
        ent_col_c = pos_c;
        ent_row_c = lo_c;
      end
      default: begin
        pos_c = crow_r - eff_r_c;
        lo_c = cmax('0, ccol_r - eff_r_c + 36'sd1);
        hi_c = cmin(colc_r - 36'sd1, ccol_r + eff_r_c);
        ent_ok_c = (pos_c >= 0) && (lo_c <= hi_c);
        ent_row_c = pos_c;
        ent_col_c = lo_c;
      end
    endcase
    ent_stop_c = hi_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_xlo_r   <= 32'sd0;
      cfg_xhi_r   <= 32'sd1;
      cfg_zlo_r   <= 32'sd0;
      cfg_zhi_r   <= 32'sd1;
      cfg_tw_r    <= 31'd1;
      cfg_td_r    <= 31'd1;
      cfg_dirs_r  <= 4'd1;
      cfg_order_r <= 1'b0;
    end else if (cfg_we) begin
      case (twg_pkg::cfg_reg_t'(cfg_index))
        twg_pkg::REG_X_LO:   cfg_xlo_r   <= cfg_data;
        twg_pkg::REG_X_HI:   cfg_xhi_r   <= cfg_data;
        twg_pkg::REG_Z_LO:   cfg_zlo_r   <= cfg_data;
        twg_pkg::REG_Z_HI:   cfg_zhi_r   <= cfg_data;
        twg_pkg::REG_TILE_W: cfg_tw_r    <= cfg_data[30:0];
        twg_pkg::REG_TILE_D: cfg_td_r    <= cfg_data[30:0];
        twg_pkg::REG_DIRS:   cfg_dirs_r  <= cfg_data[3:0];
        twg_pkg::REG_ORDER:  cfg_order_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0; row_r <= '0; colc_r <= '0; rowc_r <= '0;
      ccol_r <= '0; crow_r <= '0; radius_r <= '0; limit_r <= '0;
      stop_r <= '0; side_r <= '0; dir_r <= '0;
      hlo_r <= '0; hhi_r <= '0;
      total_r <= '0; sat_r <= 1'b0; finished_r <= 1'b1;
      item_r <= 1'b0; err_r <= 1'b0;
    end else begin
      case (op)
        twg_pkg::OP_LATCH: begin
          s_xlo_r <= cfg_xlo_r;
          s_xhi_r <= cfg_xhi_r;
          s_zlo_r <= cfg_zlo_r;
          s_zhi_r <= cfg_zhi_r;
          s_tw_r  <= (cfg_tw_r == '0) ? 31'd1 : cfg_tw_r;
          s_td_r  <= (cfg_td_r == '0) ? 31'd1 : cfg_td_r;
          if (cfg_dirs_r == '0) s_dirs_r <= 4'd1;
          else if (cfg_dirs_r > twg_pkg::DIR_CAP) s_dirs_r <= twg_pkg::DIR_CAP;
          else s_dirs_r <= cfg_dirs_r;
          s_order_r <= cfg_order_r;
          hlo_r <= in_data.y_lo;
          hhi_r <= in_data.y_hi;
          total_r <= '0;
          sat_r <= 1'b0;
          dir_r <= '0;
          side_r <= '0;
          radius_r <= '0;
          stop_r <= '0;
          item_r <= 1'b0;
          err_r <= 1'b0;
        end
        twg_pkg::OP_FETCH: begin
          item_r <= 1'b0;
          err_r <= 1'b0;
        end
        twg_pkg::OP_CHECK: begin
          xs1_r <= xs_c[31:0] - 32'd1;
          zs1_r <= zs_c[31:0] - 32'd1;
          hspan_r <= hs_c[31:0];
          div_sel_r <= '0;
          if (empty_c) begin
            finished_r <= 1'b1;
            err_r <= 1'b1;
            colc_r <= '0; rowc_r <= '0; ccol_r <= '0; crow_r <= '0;
            limit_r <= '0; col_r <= '0; row_r <= '0;
          end
        end
        twg_pkg::OP_DIV_LOAD: begin
          case (div_sel_r)
            2'd0: dq_r <= xs1_r;
            2'd1: dq_r <= zs1_r;
            2'd2: dq_r <= {1'b0, xs1_r[31:1]};
            default: dq_r <= {1'b0, zs1_r[31:1]};
          endcase
          divisor_r <= div_sel_r[0] ? s_td_r : s_tw_r;
          rem_r <= '0;
          dcnt_r <= '0;
        end
        twg_pkg::OP_DIV_STEP: begin
          rem_r <= ge_c ? rem_sh_c - {2'b00, divisor_r} : rem_sh_c;
          dq_r <= {dq_r[30:0], ge_c};
          dcnt_r <= dcnt_r + 5'd1;
        end
        twg_pkg::OP_DIV_STORE: begin
          case (div_sel_r)
            2'd0: colc_r <= q_c + 36'sd1;
            2'd1: rowc_r <= q_c + 36'sd1;
            2'd2: ccol_r <= q_c;
            default: crow_r <= q_c;
          endcase
          div_sel_r <= div_sel_r + 2'd1;
        end
        twg_pkg::OP_RST_FIN: begin
          limit_r <= cmax(cmax(ccol_r, crow_r),
                          cmax(colc_r - 36'sd1 - ccol_r, rowc_r - 36'sd1 - crow_r));
          col_r <= s_order_r ? ccol_r : '0;
          row_r <= s_order_r ? crow_r : '0;
          finished_r <= 1'b0;
        end
        twg_pkg::OP_M1: begin
          prod_r <= mul_p_c;
          dir_idx_r <= dir_r;
          item_r <= 1'b1;
        end
        twg_pkg::OP_M2: begin
          xb_r <= s_xlo_r + prod_r[31:0];
          prod_r <= mul_p_c;
        end
        twg_pkg::OP_M3: begin
          zb_r <= s_zlo_r + prod_r[31:0];
          xe_r <= (xsum_c < 34'(s_xhi_r)) ? xsum_c[31:0] : s_xhi_r;
        end
        twg_pkg::OP_M4: begin
          ze_r <= (zsum_c < 34'(s_zhi_r)) ? zsum_c[31:0] : s_zhi_r;
          xspan_r <= xe_r - xb_r;
        end
        twg_pkg::OP_M5: begin
          zspan_r <= ze_r - zb_r;
          prod_r <= mul_p_c;
        end
        twg_pkg::OP_M6: begin
          hi_r <= prod_r[63:32];
          prod_r <= mul_p_c;
        end
        twg_pkg::OP_M7: begin
          plo_r <= prod_r;
          prod_r <= mul_p_c;
        end
        twg_pkg::OP_M8: begin
          isat_r <= (prod_r[63:32] != '0) || sum_c[64];
          cnt_r <= ((prod_r[63:32] != '0) || sum_c[64]) ? '1 : sum_c[63:0];
        end
        twg_pkg::OP_M9: begin
          total_r <= tsum_c[64] ? '1 : tsum_c[63:0];
          sat_r <= sat_r | tsum_c[64] | isat_r;
        end
        twg_pkg::OP_DIR: begin
          dir_r <= wrap_c ? 3'd0 : dir_inc_c[2:0];
        end
        twg_pkg::OP_LIN: begin
          if (row_r + 36'sd1 >= rowc_r) begin
            row_r <= '0;
            col_r <= col_r + 36'sd1;
            if (col_r + 36'sd1 >= colc_r) finished_r <= 1'b1;
          end else begin
            row_r <= row_r + 36'sd1;
          end
        end
        twg_pkg::OP_SP_CONT: begin
          if (cont_c) begin
            case (side_r)
              3'd1: row_r <= row_r + 36'sd1;
              3'd2: col_r <= col_r - 36'sd1;
              3'd3: row_r <= row_r - 36'sd1;
              default: col_r <= col_r + 36'sd1;
            endcase
          end else begin
            tries_r <= '0;
            if (side_r == 3'd0 || side_r > 3'd4) begin
              try_side_r <= 3'd1;
              try_r_r <= 36'sd1;
            end else begin
              try_side_r <= side_r + 3'd1;
              try_r_r <= radius_r;
            end
          end
        end
        twg_pkg::OP_SP_TRY: begin
          if (over_c) begin
            finished_r <= 1'b1;
          end else if (ent_ok_c) begin
            col_r <= ent_col_c;
            row_r <= ent_row_c;
            stop_r <= ent_stop_c;
            side_r <= eff_side_c;
            radius_r <= eff_r_c;
          end else if (tries_r == 4'd15) begin
            finished_r <= 1'b1;
          end else begin
            try_side_r <= eff_side_c + 3'd1;
            try_r_r <= eff_r_c;
            tries_r <= tries_r + 4'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (op == twg_pkg::OP_OUT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == twg_pkg::OP_OUT) begin
      out_data_r.item_valid       <= item_r;
      out_data_r.x_begin          <= item_r ? xb_r : '0;
      out_data_r.x_end            <= item_r ? xe_r : '0;
      out_data_r.z_begin          <= item_r ? zb_r : '0;
      out_data_r.z_end            <= item_r ? ze_r : '0;
      out_data_r.direction_index  <= item_r ? dir_idx_r : '0;
      out_data_r.item_candidates  <= item_r ? cnt_r : '0;
      out_data_r.total_candidates <= total_r;
      out_data_r.total_saturated  <= sat_r;
      out_data_r.walk_done        <= finished_r;
      out_data_r.error_code       <= err_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign status.empty        = empty_c;
  assign status.div_last     = dcnt_r == 5'd31;
  assign status.div_sel_last = div_sel_r == 2'd3;
  assign status.finished     = finished_r;
  assign status.dir_wrap     = wrap_c;
  assign status.spiral       = s_order_r;
  assign status.cont_step    = cont_c;
  assign status.try_done     = over_c || ent_ok_c || (tries_r == 4'd15);
  assign status.out_free     = !out_valid_r || out_ready;

endmodule

// ===== design/twg_checker.sv =====
// Port-level checks for the tile walk generator, bound to the top level.
// Depends on twg_pkg and tile_walk_generator.
module twg_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input twg_pkg::out_item_t out_data
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Result beat changed while stalled.");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Result beat shown right after reset.");

  a_item_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.item_valid |-> out_data.error_code == 1'b0)
    else $error("Work item carries an error.");

  a_err_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.error_code |-> out_data.walk_done && !out_data.item_valid)
    else $error("Error result does not end the walk.");

  a_no_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.item_valid |-> out_data.item_candidates == 64'd0)
    else $error("Empty result carries candidates.");

endmodule

bind tile_walk_generator twg_checker u_twg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
